// ----- sv/pagq_pkg.sv -----
// pagq_pkg: shared types and constants for the pixel average / gamma quantizer
// no dependencies
`timescale 1ns / 1ps
package pagq_pkg;
    localparam int SUM_W = 26;
    localparam int CFG_W = 11;
    localparam int OUT_W = 8;
    localparam int ROOT_STEPS = 13;
    localparam logic [OUT_W-1:0] OUT_MAX = 8'd255;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [OUT_W-1:0] pix_t;
endpackage

// ----- sv/pagq_if.sv -----
// pagq_if: valid/ready channel carrying one rgb word
// parameterized by component width
`timescale 1ns / 1ps
interface pagq_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] red;
    logic [W-1:0] green;
    logic [W-1:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- sv/pagq_div_cell.sv -----
// pagq_div_cell: one restoring division step for three channels
// uses pagq_pkg
`timescale 1ns / 1ps
module pagq_div_cell #(
    parameter int DW = 11,
    parameter int BIT = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vin,
    input  logic [DW-1:0]         din,
    input  logic [3*DW-1:0]       rin,
    input  logic [3*pagq_pkg::SUM_W-1:0] qin,
    output logic                  vout,
    output logic [DW-1:0]         dout,
    output logic [3*DW-1:0]       rout,
    output logic [3*pagq_pkg::SUM_W-1:0] qout
);
    import pagq_pkg::*;
    logic [3*DW-1:0]    r_next;
    logic [3*SUM_W-1:0] q_next;
    logic               v_reg;
    logic [DW-1:0]      d_reg;
    logic [3*DW-1:0]    r_reg;
    logic [3*SUM_W-1:0] q_reg;

    always_comb
    begin
        logic [DW:0] t;
        r_next = rin;
        q_next = qin;
        for (int c = 0; c < 3; c++)
        begin
            t = {rin[c*DW +: DW], qin[c*SUM_W + BIT]};
            if (t >= {1'b0, din})
            begin
                t = t - {1'b0, din};
                q_next[c*SUM_W + BIT] = 1'b1;
            end
            else
            begin
                q_next[c*SUM_W + BIT] = 1'b0;
            end
            r_next[c*DW +: DW] = t[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= din;
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign vout = v_reg;
    assign dout = d_reg;
    assign rout = r_reg;
    assign qout = q_reg;
endmodule

// ----- sv/pagq_sqrt_cell.sv -----
// pagq_sqrt_cell: one bit-pair step of the integer square root, three channels
// uses pagq_pkg
`timescale 1ns / 1ps
module pagq_sqrt_cell #(
    parameter int STEP = 12
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic vin,
    input  logic [3*pagq_pkg::SUM_W-1:0] xin,
    input  logic [3*pagq_pkg::ROOT_STEPS-1:0] rtin,
    input  logic [3*(pagq_pkg::ROOT_STEPS+2)-1:0] remin,
    output logic vout,
    output logic [3*pagq_pkg::SUM_W-1:0] xout,
    output logic [3*pagq_pkg::ROOT_STEPS-1:0] rtout,
    output logic [3*(pagq_pkg::ROOT_STEPS+2)-1:0] remout
);
    import pagq_pkg::*;
    localparam int RW = ROOT_STEPS + 2;
    logic [3*ROOT_STEPS-1:0] rt_next;
    logic [3*RW-1:0]         rem_next;
    logic                    v_reg;
    logic [3*SUM_W-1:0]      x_reg;
    logic [3*ROOT_STEPS-1:0] rt_reg;
    logic [3*RW-1:0]         rem_reg;

    // remainder gets next two bits, trial subtract 4*root+1
    always_comb
    begin
        logic [RW+1:0] t;
        logic [RW+1:0] d;
        for (int c = 0; c < 3; c++)
        begin
            t = {remin[c*RW +: RW], xin[c*SUM_W + 2*STEP +: 2]};
            d = {2'b00, rtin[c*ROOT_STEPS +: ROOT_STEPS], 2'b01};
            if (t >= d)
            begin
                rem_next[c*RW +: RW] = RW'(t - d);
                rt_next[c*ROOT_STEPS +: ROOT_STEPS] =
                    {rtin[c*ROOT_STEPS +: ROOT_STEPS-1], 1'b1};
            end
            else
            begin
                rem_next[c*RW +: RW] = t[RW-1:0];
                rt_next[c*ROOT_STEPS +: ROOT_STEPS] =
                    {rtin[c*ROOT_STEPS +: ROOT_STEPS-1], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= xin;
            rt_reg  <= rt_next;
            rem_reg <= rem_next;
        end
    end

    assign vout   = v_reg;
    assign xout   = x_reg;
    assign rtout  = rt_reg;
    assign remout = rem_reg;
endmodule

// ----- sv/pixel_average_gamma2_quantize_unit.sv -----
// pixel_average_gamma2_quantize_unit: top level, divider chain then root chain
// uses pagq_pkg, pagq_if, pagq_div_cell, pagq_sqrt_cell
`timescale 1ns / 1ps
// Takes one rgb sum word per cycle while the chain is not held and returns
// min(255, floor(sqrt(sum / n))) per channel, n being the configured sample
// count (0 read as 1, capped at MAX_SAMPLES). Rate is one word per cycle while
// not held. Each word passes through 26 division cells (one quotient bit each)
// and then 13 root cells (one root bit each). The whole chain advances together
// and holds when the output word is not taken.
module pixel_average_gamma2_quantize_unit #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [pagq_pkg::CFG_W-1:0] cfg_wdata,
    pagq_if.sink   sum_ch,
    pagq_if.source pix_ch
);
    import pagq_pkg::*;
    localparam int DW = $clog2(MAX_SAMPLES + 1);
    localparam int RW = ROOT_STEPS + 2;

    logic [CFG_W-1:0] spp_reg;
    logic [DW-1:0]    cnt;
    logic             en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spp_reg <= CFG_W'(1);
        else if (cfg_we)
            spp_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (spp_reg == '0)
            cnt = DW'(1);
        else if (32'(spp_reg) > MAX_SAMPLES)
            cnt = DW'(MAX_SAMPLES);
        else
            cnt = DW'(spp_reg);
    end

    logic dv [SUM_W+1];
    logic [DW-1:0] dd [SUM_W+1];
    logic [3*DW-1:0] dr [SUM_W+1];
    logic [3*SUM_W-1:0] dq [SUM_W+1];

    assign dv[0] = sum_ch.valid;
    assign dd[0] = cnt;
    assign dr[0] = '0;
    assign dq[0] = {sum_ch.blue, sum_ch.green, sum_ch.red};

    genvar i;
    generate
        for (i = 0; i < SUM_W; i++)
        begin : g_div
            pagq_div_cell #(.DW(DW), .BIT(SUM_W-1-i)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .vin(dv[i]), .din(dd[i]), .rin(dr[i]), .qin(dq[i]),
                .vout(dv[i+1]), .dout(dd[i+1]), .rout(dr[i+1]), .qout(dq[i+1])
            );
        end
    endgenerate

    logic sv [ROOT_STEPS+1];
    logic [3*SUM_W-1:0] sx [ROOT_STEPS+1];
    logic [3*ROOT_STEPS-1:0] srt [ROOT_STEPS+1];
    logic [3*RW-1:0] srem [ROOT_STEPS+1];

    assign sv[0]   = dv[SUM_W];
    assign sx[0]   = dq[SUM_W];
    assign srt[0]  = '0;
    assign srem[0] = '0;

    generate
        for (i = 0; i < ROOT_STEPS; i++)
        begin : g_sqrt
            pagq_sqrt_cell #(.STEP(ROOT_STEPS-1-i)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .vin(sv[i]), .xin(sx[i]), .rtin(srt[i]), .remin(srem[i]),
                .vout(sv[i+1]), .xout(sx[i+1]), .rtout(srt[i+1]), .remout(srem[i+1])
            );
        end
    endgenerate

    assign en = pix_ch.ready || !sv[ROOT_STEPS];
    assign sum_ch.ready = en;

    function automatic pix_t sat(input logic [ROOT_STEPS-1:0] r);
        if (r > ROOT_STEPS'(OUT_MAX))
            sat = OUT_MAX;
        else
            sat = r[OUT_W-1:0];
    endfunction

    assign pix_ch.valid = sv[ROOT_STEPS];
    assign pix_ch.red   = sat(srt[ROOT_STEPS][0 +: ROOT_STEPS]);
    assign pix_ch.green = sat(srt[ROOT_STEPS][ROOT_STEPS +: ROOT_STEPS]);
    assign pix_ch.blue  = sat(srt[ROOT_STEPS][2*ROOT_STEPS +: ROOT_STEPS]);
endmodule

// ----- verif/pagq_checker.sv -----
// pagq_checker: watches the sum and pixel channels, predicts each pixel and compares
// depends on pagq_pkg and pagq_if
`timescale 1ns / 1ps
module pagq_checker #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [pagq_pkg::CFG_W-1:0] cfg_wdata,
    pagq_if in_ch,
    pagq_if out_ch,
    output int fail_count,
    output int pending
);
    import pagq_pkg::*;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
    } rgb_pix_t;

    logic [CFG_W-1:0] samples_copy;
    rgb_pix_t         pixel_queue[$];

    // zero count reads as one, large counts are capped
    function automatic int unsigned sample_divisor(logic [CFG_W-1:0] n);
        int unsigned d;
        d = 32'(n);
        if (d == 0)
            d = 1;
        if (d > MAX_SAMPLES)
            d = MAX_SAMPLES;
        return d;
    endfunction

    function automatic pix_t gamma_pixel(sum_t s, int unsigned d);
        longint unsigned q;
        longint unsigned r;
        longint unsigned t;
        q = s / d;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= q)
                r = t;
        end
        if (r > OUT_MAX)
            r = OUT_MAX;
        return pix_t'(r);
    endfunction

    task automatic report_mismatch(string what, pix_t got, pix_t want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgb_pix_t p;
        rgb_pix_t w;
        int unsigned d;
        if (!rst_n)
        begin
            samples_copy = CFG_W'(1);
            pixel_queue.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                samples_copy = cfg_wdata;
            if (in_ch.valid && in_ch.ready)
            begin
                d = sample_divisor(samples_copy);
                p.red   = gamma_pixel(in_ch.red, d);
                p.green = gamma_pixel(in_ch.green, d);
                p.blue  = gamma_pixel(in_ch.blue, d);
                pixel_queue.push_back(p);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    $display("unexpected pixel word at %0t", $realtime);
                    fail_count++;
                end
                else
                begin
                    w = pixel_queue.pop_front();
                    if (out_ch.red != w.red)
                        report_mismatch("red", out_ch.red, w.red);
                    if (out_ch.green != w.green)
                        report_mismatch("green", out_ch.green, w.green);
                    if (out_ch.blue != w.blue)
                        report_mismatch("blue", out_ch.blue, w.blue);
                end
            end
            pending = pixel_queue.size();
        end
    end

    initial fail_count = 0;
endmodule

// ----- verif/testbench.sv -----
// testbench: stimulus and verdict for pixel_average_gamma2_quantize_unit
// depends on pagq_pkg, pagq_if, pagq_checker and the unit itself
`timescale 1ns / 1ps
module testbench;
    import pagq_pkg::*;

    localparam int LATENCY = 39;
    localparam int IDLE_LIMIT = 20000;
    localparam int MAX_N = 1024;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    int fail_count;
    int pending;
    idle_mode_t idle_mode = IDLE_NONE;
    bit hold_start = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    logic [CFG_W-1:0] cur_count = CFG_W'(1);

    pagq_if #(SUM_W) in_ch ();
    pagq_if #(OUT_W) out_ch ();

    initial
    begin
        in_ch.valid = 0;
        in_ch.red = '0;
        in_ch.green = '0;
        in_ch.blue = '0;
        out_ch.ready = 0;
    end

    always #5 clk = ~clk;

    pixel_average_gamma2_quantize_unit #(.MAX_SAMPLES(MAX_N)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .sum_ch(in_ch), .pix_ch(out_ch)
    );

    pagq_checker #(.MAX_SAMPLES(MAX_N)) checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending)
    );

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left = 300;
            hold_start = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 0;
        end
        else if (idle_mode == IDLE_RECV)
            out_ch.ready <= ($urandom_range(99) >= 60);
        else if (idle_mode == IDLE_BOTH)
            out_ch.ready <= ($urandom_range(99) >= 10);
        else
            out_ch.ready <= 1;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired");
            $display("pixel_average_gamma2_quantize_unit regression: fail");
            $finish;
        end
    end

    // called at a rising edge, returns at or after the edge where the word was taken
    task automatic push_sums(sum_t r, sum_t g, sum_t b);
        int pct;
        in_ch.valid <= 1;
        in_ch.red <= r;
        in_ch.green <= g;
        in_ch.blue <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pct = (idle_mode == IDLE_SEND) ? 60 : (idle_mode == IDLE_BOTH) ? 10 : 0;
        if ($urandom_range(99) < pct)
        begin
            in_ch.valid <= 0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_count(logic [CFG_W-1:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        cur_count = v;
    endtask

    function automatic sum_t pick_sum();
        int unsigned d;
        longint unsigned top;
        d = (cur_count == 0) ? 1 : (cur_count > MAX_N) ? MAX_N : cur_count;
        top = longint'(d) * 65536 - 1;
        if (top > 64'h3FFFFFF)
            top = 64'h3FFFFFF;
        case ($urandom_range(9))
            0: return sum_t'($urandom);
            1: return sum_t'(top);
            default: return sum_t'($urandom_range(int'(top), 0));
        endcase
    endfunction

    task automatic random_run(int count);
        repeat (count)
            push_sums(pick_sum(), pick_sum(), pick_sum());
    endtask

    initial
    begin
        static logic [CFG_W-1:0] counts[8] = '{11'd0, 11'd1024, 11'd2047, 11'd3, 11'd37,
                                               11'd1000, 11'd1025, 11'd1};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed, first at the reset count of one, then at other counts
        push_sums('0, '0, '0);
        push_sums('1, '1, '1);
        push_sums('1, '0, '0);
        push_sums('0, '1, '0);
        push_sums('0, '0, '1);
        push_sums(26'd65535, 26'd65536, 26'd16777216);
        push_sums(26'd4194303, 26'd4194304, 26'h2AAAAAA);
        push_sums(26'h1555555, 26'd1, 26'd3);
        set_count(11'd0);
        push_sums(26'd65535, 26'd65536, '1);
        set_count(11'd2047);
        push_sums('1, '0, 26'd67043328);
        push_sums(26'd67108863 - 26'd65536, 26'd1024, 26'd1023);
        set_count(11'd1024);
        push_sums('1, 26'd66060288, 26'd66060289);
        set_count(11'd1025);
        push_sums('1, 26'd1024, 26'd4096);
        set_count(11'd255);
        push_sums(26'd16711680, 26'd16711679, '1);

        for (int ph = 0; ph < 8; ph++)
        begin
            set_count(counts[ph]);
            idle_mode = idle_mode_t'(ph % 4);
            if (ph == 2)
            begin
                hold_start = 1;
                random_run(120);
            end
            else
                random_run(90);
            if (ph == 5)
            begin
                // sender waits for every pixel to come back
                drain();
                random_run(30);
            end
        end
        idle_mode = IDLE_NONE;
        random_run(60);

        drain();
        if (fail_count == 0)
            $display("pixel_average_gamma2_quantize_unit regression: pass");
        else
            $display("pixel_average_gamma2_quantize_unit regression: fail");
        $finish;
    end
endmodule

// ----- pixel_average_gamma2_quantize_unit.f -----
sv/pagq_pkg.sv
sv/pagq_if.sv
sv/pagq_div_cell.sv
sv/pagq_sqrt_cell.sv
sv/pixel_average_gamma2_quantize_unit.sv
verif/pagq_checker.sv
verif/testbench.sv
